// ===== rtl/tac_pkg.sv =====
// Shared types and constants for the tactile array centroid block.
// Depends on nothing; imported by tactile_array_centroid, its checker and its testbench.
`timescale 1ns / 1ps

package tac_pkg;

  localparam int NUM_SENSORS = 40;
  localparam int SENS_AW     = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  localparam int SENSOR_W = 6;
  localparam int RAW_W    = 32;
  localparam int POS_W    = 16;
  localparam int PRESS_W  = 10;
  localparam int CALIB_W  = 8;
  localparam int BASE_W   = 20;
  localparam int DIFF_W   = 21;
  localparam int PROD_W   = DIFF_W + POS_W;
  localparam int WACC_W   = 48;
  localparam int PACC_W   = 32;
  localparam int CENT_W   = 32;
  localparam int CNT_W    = $clog2(WACC_W);

  localparam int IN_FIELDS_W = SENSOR_W + RAW_W + 2 * POS_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 2 * CENT_W;

  localparam logic [CALIB_W-1:0] CALIB_RESET = CALIB_W'(10);

  typedef enum logic [1:0] {
    KIND_POS  = 2'd0,
    KIND_CLR  = 2'd1,
    KIND_CAL  = 2'd2,
    KIND_MEAS = 2'd3
  } tac_kind_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_MAC  = 6'b000100,
    ST_FIN  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } tac_state_t;

endpackage

// ===== rtl/tactile_array_centroid.sv =====
// Tactile array centroid: per-sensor position and baseline memories, frame
// accumulators and a bit-serial divider for the frame-end centroid.
// Depends on tac_pkg.
`timescale 1ns / 1ps

// Sequence: a position load or a baseline clear completes while idle; a calibration record
// reads, then writes back; a measurement record reads, differences, then multiply-accumulates.
// A frame end adds a check, the divider (skipped on a zero total) and the output register load,
// which waits while an earlier result still waits there. A new record is taken only when idle.
// Reset (rst_n low, synchronous) clears the accumulators, the memory valid bits and sets
// calib_frames to 10; no clearing pass is needed.
module tactile_array_centroid (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration: calib_frames
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tac_pkg::CALIB_W-1:0]      cfg_data,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // from bit 0: sensor[5:0], raw_record[37:6], pos_x[53:38], pos_y[69:54], zero pad
  input  logic [tac_pkg::IN_TDATA_W-1:0]   in_tdata,
  // kind[1:0]
  input  logic [1:0]                       in_tuser,
  // last_in_frame
  input  logic                             in_tlast,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // from bit 0: centroid_x[31:0], centroid_y[63:32]
  output logic [tac_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // status[0]
  output logic                             out_tuser
);

  import tac_pkg::*;

  // input field unpack
  logic [SENSOR_W-1:0]      in_sensor;
  logic [RAW_W-1:0]         in_raw;
  logic [POS_W-1:0]         in_pos_x;
  logic [POS_W-1:0]         in_pos_y;
  logic                     in_ok;
  logic                     in_acc;
  tac_kind_t                in_kind;
  logic [SENS_AW-1:0]       in_idx;

  assign in_sensor = in_tdata[SENSOR_W-1:0];
  assign in_raw    = in_tdata[SENSOR_W +: RAW_W];
  assign in_pos_x  = in_tdata[SENSOR_W + RAW_W +: POS_W];
  assign in_pos_y  = in_tdata[SENSOR_W + RAW_W + POS_W +: POS_W];
  assign in_kind   = tac_kind_t'(in_tuser);
  assign in_ok     = {1'b0, in_sensor} < (SENSOR_W + 1)'(NUM_SENSORS);
  assign in_idx    = in_sensor[SENS_AW-1:0];

  tac_state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // configuration register
  logic [CALIB_W-1:0] calib_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r <= CALIB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      calib_r <= cfg_data;
    end
  end

  // per-item registers
  tac_kind_t               kind_r;
  logic [SENS_AW-1:0]      idx_r;
  logic                    ok_r;
  logic                    last_r;
  logic signed [PRESS_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_kind;
      idx_r  <= in_idx;
      ok_r   <= in_ok;
      last_r <= in_tlast;
      p_r    <= signed'({in_raw[31:24], in_raw[23:22]});
    end
  end

  // memories: position {y, x} and baseline sum, one read port each
  logic [2*POS_W-1:0]      pos_mem [NUM_SENSORS];
  logic [BASE_W-1:0]       base_mem [NUM_SENSORS];
  logic [NUM_SENSORS-1:0]  pos_valid_r;
  logic [NUM_SENSORS-1:0]  base_valid_r;
  logic [2*POS_W-1:0]      pos_rd_r;
  logic [BASE_W-1:0]       base_rd_r;
  logic                    pos_rd_vld_r;
  logic                    base_rd_vld_r;
  logic                    rd_en;
  logic                    pos_wr;
  logic                    base_wr;
  logic [BASE_W-1:0]       base_wdata;

  assign rd_en   = in_acc && in_ok && (in_kind == KIND_CAL || in_kind == KIND_MEAS);
  assign pos_wr  = in_acc && in_ok && (in_kind == KIND_POS);
  assign base_wr = (state_r == ST_RD) && ok_r && (kind_r == KIND_CAL);

  always_ff @(posedge clk) begin
    if (pos_wr) begin
      pos_mem[in_idx] <= {in_pos_y, in_pos_x};
    end
    if (base_wr) begin
      base_mem[idx_r] <= base_wdata;
    end
    if (rd_en) begin
      pos_rd_r      <= pos_mem[in_idx];
      base_rd_r     <= base_mem[in_idx];
      pos_rd_vld_r  <= pos_valid_r[in_idx];
      base_rd_vld_r <= base_valid_r[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_valid_r  <= '0;
      base_valid_r <= '0;
    end else begin
      if (pos_wr) begin
        pos_valid_r[in_idx] <= 1'b1;
      end
      if (in_acc && in_kind == KIND_CLR) begin
        base_valid_r <= '0;
      end else if (base_wr) begin
        base_valid_r[idx_r] <= 1'b1;
      end
    end
  end

  // read-modify stage: an entry never written reads as zero
  logic signed [BASE_W-1:0]  base_cur;
  logic signed [POS_W-1:0]   pos_x_cur;
  logic signed [POS_W-1:0]   pos_y_cur;
  logic [CALIB_W-1:0]        n_eff;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DIFF_W-1:0]  diff_r;

  assign base_cur   = base_rd_vld_r ? signed'(base_rd_r) : '0;
  assign pos_x_cur  = pos_rd_vld_r ? signed'(pos_rd_r[POS_W-1:0]) : '0;
  assign pos_y_cur  = pos_rd_vld_r ? signed'(pos_rd_r[2*POS_W-1:POS_W]) : '0;
  assign n_eff      = (calib_r == '0) ? CALIB_W'(1) : calib_r;
  assign base_wdata = BASE_W'(base_cur + BASE_W'(p_r));
  assign diff       = DIFF_W'(signed'({1'b0, n_eff})) * DIFF_W'(p_r) - DIFF_W'(base_cur);

  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      diff_r <= diff;
    end
  end

  // multiply-accumulate with saturation
  logic signed [WACC_W-1:0] wx_r, wy_r, wx_nxt, wy_nxt;
  logic signed [PACC_W-1:0] pa_r, pa_nxt;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [WACC_W:0]   sum_x, sum_y;
  logic signed [PACC_W:0]   sum_p;

  function automatic logic signed [WACC_W-1:0] sat_w(input logic signed [WACC_W:0] v);
    logic signed [WACC_W-1:0] r;
    if (v[WACC_W] != v[WACC_W-1]) begin
      r = v[WACC_W] ? {1'b1, {(WACC_W-1){1'b0}}} : {1'b0, {(WACC_W-1){1'b1}}};
    end else begin
      r = v[WACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [PACC_W-1:0] sat_p(input logic signed [PACC_W:0] v);
    logic signed [PACC_W-1:0] r;
    if (v[PACC_W] != v[PACC_W-1]) begin
      r = v[PACC_W] ? {1'b1, {(PACC_W-1){1'b0}}} : {1'b0, {(PACC_W-1){1'b1}}};
    end else begin
      r = v[PACC_W-1:0];
    end
    return r;
  endfunction

  assign prod_x = PROD_W'(diff_r) * PROD_W'(pos_x_cur);
  assign prod_y = PROD_W'(diff_r) * PROD_W'(pos_y_cur);
  assign sum_x  = (WACC_W + 1)'(wx_r) + (WACC_W + 1)'(prod_x);
  assign sum_y  = (WACC_W + 1)'(wy_r) + (WACC_W + 1)'(prod_y);
  assign sum_p  = (PACC_W + 1)'(pa_r) + (PACC_W + 1)'(diff_r);

  // divider: restoring, one quotient bit per cycle, x and y side by side
  logic [WACC_W-1:0]  qx_r, qy_r;
  logic [PACC_W-1:0]  rx_r, ry_r;
  logic [PACC_W-1:0]  den_r;
  logic               negx_r, negy_r;
  logic               zero_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PACC_W:0]    rx_sh, ry_sh, rx_sub, ry_sub;
  logic               bx, by;

  assign rx_sh  = {rx_r, qx_r[WACC_W-1]};
  assign ry_sh  = {ry_r, qy_r[WACC_W-1]};
  assign rx_sub = rx_sh - {1'b0, den_r};
  assign ry_sub = ry_sh - {1'b0, den_r};
  assign bx     = !rx_sub[PACC_W];
  assign by     = !ry_sub[PACC_W];

  // magnitudes at frame end
  logic [WACC_W-1:0] mag_x, mag_y;
  logic [PACC_W-1:0] mag_p;
  assign mag_x = wx_r[WACC_W-1] ? WACC_W'(-wx_r) : WACC_W'(wx_r);
  assign mag_y = wy_r[WACC_W-1] ? WACC_W'(-wy_r) : WACC_W'(wy_r);
  assign mag_p = pa_r[PACC_W-1] ? PACC_W'(-pa_r) : PACC_W'(pa_r);

  always_comb begin
    wx_nxt = wx_r;
    wy_nxt = wy_r;
    pa_nxt = pa_r;
    if (state_r == ST_MAC && ok_r) begin
      wx_nxt = sat_w(sum_x);
      wy_nxt = sat_w(sum_y);
      pa_nxt = sat_p(sum_p);
    end else if (state_r == ST_FIN) begin
      wx_nxt = '0;
      wy_nxt = '0;
      pa_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wx_r <= '0;
      wy_r <= '0;
      pa_r <= '0;
    end else begin
      wx_r <= wx_nxt;
      wy_r <= wy_nxt;
      pa_r <= pa_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN) begin
      zero_r <= (pa_r == '0);
      negx_r <= wx_r[WACC_W-1] ^ pa_r[PACC_W-1];
      negy_r <= wy_r[WACC_W-1] ^ pa_r[PACC_W-1];
      den_r  <= mag_p;
      rx_r   <= '0;
      ry_r   <= '0;
      cnt_r  <= '0;
      // zero denominator skips the divider: clear the quotient instead
      qx_r   <= (pa_r == '0) ? '0 : mag_x;
      qy_r   <= (pa_r == '0) ? '0 : mag_y;
    end else if (state_r == ST_DIV) begin
      rx_r  <= bx ? rx_sub[PACC_W-1:0] : rx_sh[PACC_W-1:0];
      ry_r  <= by ? ry_sub[PACC_W-1:0] : ry_sh[PACC_W-1:0];
      qx_r  <= {qx_r[WACC_W-2:0], bx};
      qy_r  <= {qy_r[WACC_W-2:0], by};
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // apply sign and saturate the quotient to 32 bits
  function automatic logic [CENT_W-1:0] sat_q(input logic [WACC_W-1:0] mag, input logic neg);
    logic [CENT_W-1:0] r;
    if (neg) begin
      if (mag > WACC_W'({1'b1, {(CENT_W-1){1'b0}}})) begin
        r = {1'b1, {(CENT_W-1){1'b0}}};
      end else begin
        r = CENT_W'(-mag[CENT_W-1:0]);
      end
    end else begin
      if (mag > WACC_W'({1'b0, {(CENT_W-1){1'b1}}})) begin
        r = {1'b0, {(CENT_W-1){1'b1}}};
      end else begin
        r = mag[CENT_W-1:0];
      end
    end
    return r;
  endfunction

  // output register
  logic                    out_valid_r;
  logic [OUT_TDATA_W-1:0]  out_data_r;
  logic                    out_status_r;
  logic                    out_load;

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r   <= {sat_q(qy_r, negy_r), sat_q(qx_r, negx_r)};
      out_status_r <= zero_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_kind) inside
            KIND_CAL, KIND_MEAS: state_nxt = ST_RD;
            default:             state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD:   state_nxt = (kind_r == KIND_MEAS) ? ST_MAC : ST_IDLE;
      ST_MAC:  state_nxt = last_r ? ST_FIN : ST_IDLE;
      ST_FIN:  state_nxt = (pa_r == '0) ? ST_OUT : ST_DIV;
      ST_DIV:  state_nxt = (cnt_r == CNT_W'(WACC_W - 1)) ? ST_OUT : ST_DIV;
      ST_OUT:  state_nxt = out_load ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== tb/tactile_array_centroid_checker.sv =====
// Scoreboard for the tactile array centroid: tracks the calibration register,
// predicts each frame-end centroid from the input words and checks the results.
// Depends on tac_pkg.
`timescale 1ns / 1ps

module tactile_array_centroid_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [tac_pkg::CALIB_W-1:0]      cfg_data,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [tac_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [1:0]                       in_tuser,
  input  logic                             in_tlast,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [tac_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             out_tuser,
  output int                               fail_count,
  output int                               open_results
);

  import tac_pkg::*;

  typedef struct packed {
    logic signed [CENT_W-1:0] cx;
    logic signed [CENT_W-1:0] cy;
    logic                     zero_press;
  } centroid_t;

  logic [CALIB_W-1:0]       calib;
  logic signed [POS_W-1:0]  x_tab [NUM_SENSORS];
  logic signed [POS_W-1:0]  y_tab [NUM_SENSORS];
  logic signed [BASE_W-1:0] base_tab [NUM_SENSORS];
  longint                   wx_sum, wy_sum, press_sum;
  centroid_t                centroid_q [$];
  int                       errs = 0;

  assign fail_count = errs;

  function automatic longint clamp_signed(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  task automatic apply_word(input logic [IN_TDATA_W-1:0] data, input logic [1:0] kind,
                            input logic last);
    logic [SENSOR_W-1:0]       s;
    logic [RAW_W-1:0]          raw;
    logic signed [PRESS_W-1:0] p;
    longint                    n;
    longint                    d;
    centroid_t                 c;
    s   = data[SENSOR_W-1:0];
    raw = data[SENSOR_W +: RAW_W];
    p   = {raw[31:24], raw[23:22]};
    case (tac_kind_t'(kind))
      KIND_POS: begin
        if (s < NUM_SENSORS) begin
          x_tab[s] = data[SENSOR_W+RAW_W +: POS_W];
          y_tab[s] = data[SENSOR_W+RAW_W+POS_W +: POS_W];
        end
      end
      KIND_CLR: begin
        for (int i = 0; i < NUM_SENSORS; i++) base_tab[i] = '0;
      end
      KIND_CAL: begin
        // wrap within the baseline width
        if (s < NUM_SENSORS) base_tab[s] = BASE_W'(longint'(base_tab[s]) + longint'(p));
      end
      default: begin
        if (s < NUM_SENSORS) begin
          n = (calib == 0) ? 1 : longint'(calib);
          d = n * longint'(p) - longint'(base_tab[s]);
          wx_sum    = clamp_signed(wx_sum + d * longint'(x_tab[s]), WACC_W);
          wy_sum    = clamp_signed(wy_sum + d * longint'(y_tab[s]), WACC_W);
          press_sum = clamp_signed(press_sum + d, PACC_W);
        end
        if (last) begin
          if (press_sum == 0) begin
            c.cx = '0;
            c.cy = '0;
            c.zero_press = 1'b1;
          end else begin
            c.cx = CENT_W'(clamp_signed(wx_sum / press_sum, CENT_W));
            c.cy = CENT_W'(clamp_signed(wy_sum / press_sum, CENT_W));
            c.zero_press = 1'b0;
          end
          centroid_q.push_back(c);
          wx_sum    = 0;
          wy_sum    = 0;
          press_sum = 0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : scoreboard
    centroid_t got;
    centroid_t want;
    if (!rst_n) begin
      calib     = CALIB_RESET;
      wx_sum    = 0;
      wy_sum    = 0;
      press_sum = 0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        x_tab[i]    = '0;
        y_tab[i]    = '0;
        base_tab[i] = '0;
      end
    end else begin
      // results leave long after their frame ends, so check before predicting
      if (out_tvalid && out_tready) begin
        got.cx         = out_tdata[CENT_W-1:0];
        got.cy         = out_tdata[2*CENT_W-1:CENT_W];
        got.zero_press = out_tuser;
        if (centroid_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected result x=%0d y=%0d status=%0b",
                     $realtime, got.cx, got.cy, got.zero_press);
        end else begin
          want = centroid_q.pop_front();
          if (got.cx !== want.cx || got.cy !== want.cy ||
              got.zero_press !== want.zero_press) begin
            errs++;
            if (errs <= 10)
              $display({"%0t: centroid mismatch exp x=%0d y=%0d status=%0b,",
                        " got x=%0d y=%0d status=%0b"},
                       $realtime, want.cx, want.cy, want.zero_press,
                       got.cx, got.cy, got.zero_press);
          end
        end
      end
      if (cfg_valid && cfg_ready) calib = cfg_data;
      if (in_tvalid && in_tready) apply_word(in_tdata, in_tuser, in_tlast);
    end
    open_results <= centroid_q.size();
  end

endmodule

// ===== tb/tactile_array_centroid_tb.sv =====
// Top of the tactile array centroid testbench: clock, reset, stimulus and verdict.
// Depends on tac_pkg, tactile_array_centroid and tactile_array_centroid_checker.
`timescale 1ns / 1ps

module tactile_array_centroid_tb;
  import tac_pkg::*;

  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT   = 5000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CALIB_W-1:0]      cfg_data = '0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic [1:0]              in_tuser = '0;
  logic                    in_tlast = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tuser;

  int fail_count;
  int open_results;
  int send_idle = 14;
  int recv_idle = 63;
  int words_sent = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  tactile_array_centroid dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  tactile_array_centroid_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // pressure in the top ten bits, random filler below
  function automatic logic [RAW_W-1:0] rec_with(input logic [PRESS_W-1:0] p);
    return {p, 22'($urandom())};
  endfunction

  function automatic logic [SENSOR_W-1:0] pick_sensor();
    if ($urandom_range(9) == 0) return SENSOR_W'($urandom_range(63));
    return SENSOR_W'($urandom_range(NUM_SENSORS - 1));
  endfunction

  task automatic push_word(input tac_kind_t kind, input logic [SENSOR_W-1:0] s,
                           input logic [RAW_W-1:0] raw, input logic [POS_W-1:0] px,
                           input logic [POS_W-1:0] py, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tlast  <= last;
    in_tdata  <= {2'b00, py, px, raw, s};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic push_random(input tac_kind_t kind, input logic [SENSOR_W-1:0] s,
                             input logic last);
    push_word(kind, s, $urandom(), 16'($urandom()), 16'($urandom()), last);
  endtask

  // hold off until every frame result is out and the divider has had time to finish
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_calib(input logic [CALIB_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int stop_at;
    int r;
    int len;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 10) begin
        len = $urandom_range(4, 1);
        repeat (len) push_random(KIND_POS, pick_sensor(), $urandom_range(1));
      end else if (r < 18) begin
        push_random(KIND_CLR, SENSOR_W'($urandom()), $urandom_range(1));
        len = $urandom_range(6, 1);
        repeat (len) push_random(KIND_CAL, pick_sensor(), $urandom_range(1));
      end else if (r < 85) begin
        // a well-formed frame, now and then with a stray word inside
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(15) == 0)
            push_random(tac_kind_t'($urandom_range(2)), pick_sensor(), $urandom_range(1));
          push_random(KIND_MEAS, pick_sensor(), i == len - 1);
        end
      end else begin
        push_random(tac_kind_t'($urandom_range(3)), SENSOR_W'($urandom()),
                    $urandom_range(1));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners first, on the reset calibration count
    push_word(KIND_POS, 6'd0, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 1'b1);
    push_word(KIND_POS, 6'd1, 32'h0000_0000, 16'h0000, 16'h0123, 1'b0);
    push_word(KIND_POS, 6'd63, 32'h0, 16'h1234, 16'h4321, 1'b0);
    push_word(KIND_MEAS, 6'd0, rec_with(10'h200), 16'hFFFF, 16'hFFFF, 1'b1);
    write_calib(8'd255);
    push_word(KIND_MEAS, 6'd45, rec_with(10'h1FF), 16'h0, 16'h0, 1'b1);
    push_word(KIND_CAL, 6'd1, 32'hFFC0_0000, 16'h0, 16'h0, 1'b1);
    // nearly cancelling terms: tiny denominator, saturated centroid
    push_word(KIND_MEAS, 6'd0, rec_with(10'h1FF), 16'h0, 16'h0, 1'b0);
    push_word(KIND_MEAS, 6'd1, rec_with(10'h201), 16'h0, 16'h0, 1'b1);
    push_word(KIND_CLR, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_word(KIND_MEAS, 6'd1, rec_with(10'h000), 16'h0, 16'h0, 1'b0);
    push_word(KIND_MEAS, 6'd40, rec_with(10'h1FF), 16'h0, 16'h0, 1'b1);
    push_word(KIND_CAL, 6'd0, rec_with(10'h1FF), 16'h0, 16'h0, 1'b0);
    push_word(KIND_CAL, 6'd0, rec_with(10'h1FF), 16'h0, 16'h0, 1'b0);
    push_word(KIND_CAL, 6'd50, rec_with(10'h1FF), 16'h0, 16'h0, 1'b0);
    push_word(KIND_MEAS, 6'd0, 32'h0000_0000, 16'h0, 16'h0, 1'b1);
    push_word(KIND_POS, 6'd39, 32'h0, 16'h8000, 16'h7FFF, 1'b0);
    push_word(KIND_MEAS, 6'd39, 32'hFFFF_FFFF, 16'h0, 16'h0, 1'b1);
    push_word(KIND_MEAS, 6'd2, 32'h0000_FFFF, 16'h0, 16'h0, 1'b1);

    write_calib(8'd0);
    run_random(250);

    write_calib(8'd1);
    send_idle = 63;
    recv_idle = 14;
    run_random(250);

    write_calib(CALIB_W'($urandom_range(254, 2)));
    send_idle = 0;
    recv_idle = 0;
    run_random(250);

    // one long frame on a single sensor at the largest calibration count
    write_calib(8'd255);
    push_word(KIND_CLR, 6'd0, 32'h0, 16'h0, 16'h0, 1'b0);
    push_word(KIND_POS, 6'd2, 32'h0, 16'h8000, 16'h7FFF, 1'b0);
    repeat (30) push_word(KIND_CAL, 6'd2, rec_with(10'h1FF), 16'h0, 16'h0, 1'b0);
    repeat (29) push_word(KIND_MEAS, 6'd2, rec_with(10'h1FF), 16'h0, 16'h0, 1'b0);
    push_word(KIND_MEAS, 6'd2, rec_with(10'h1FF), 16'h0, 16'h0, 1'b1);

    drain();
    if (fail_count == 0 && open_results == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
